>>> design/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define PEI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PEI_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define PEI_ASSERT(lbl, clk, rstn, prop, msg)
`define PEI_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

>>> design/pei_pkg.sv
`default_nettype none

package pei_pkg;

  typedef logic signed [31:0] q16_t;
  typedef q16_t [2:0] vec3_t;

  localparam logic [1:0] FUNC_FORCE = 2'd0;
  localparam logic [1:0] FUNC_STEP  = 2'd1;
  localparam logic [1:0] FUNC_LOADP = 2'd2;
  localparam logic [1:0] FUNC_LOADV = 2'd3;

  // integrate sequence, one product issued per step
  localparam logic [2:0] STEP_ISSUE = 3'd0;
  localparam logic [2:0] STEP_ACC   = 3'd1;
  localparam logic [2:0] STEP_POS1  = 3'd2;
  localparam logic [2:0] STEP_VEL1  = 3'd3;
  localparam logic [2:0] STEP_POS2  = 3'd4;
  localparam logic [2:0] STEP_VEL2  = 3'd5;
  localparam logic [2:0] STEP_LAST  = STEP_VEL2;

  localparam q16_t Q16_MAX = 32'sh7FFF_FFFF;
  localparam q16_t Q16_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic       start;
    logic [1:0] func;
    logic       run;
    logic [2:0] step;
  } lane_cmd_t;

  typedef struct packed {
    q16_t val;
    logic sat;
  } q16_res_t;

  // round to nearest (ties up) at 16 bits, then clamp to 32 bits
  function automatic q16_res_t mul_post(input logic signed [63:0] prod);
    logic signed [63:0] y;
    logic signed [47:0] s;
    q16_res_t r;
    y = prod + 64'sd32768;
    s = y[63:16];
    if (s > 48'sh0000_7FFF_FFFF) begin
      r.val = Q16_MAX;
      r.sat = 1'b1;
    end else if (s < -48'sh0000_8000_0000) begin
      r.val = Q16_MIN;
      r.sat = 1'b1;
    end else begin
      r.val = s[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic q16_res_t sat_add(input q16_t a, input q16_t b);
    logic signed [32:0] s;
    q16_res_t r;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      r.val = s[32] ? Q16_MIN : Q16_MAX;
      r.sat = 1'b1;
    end else begin
      r.val = s[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/pei_if.sv
`default_nettype none

interface pei_in_if;
  import pei_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  q16_t       vec_x;
  q16_t       vec_y;
  q16_t       vec_z;

  modport source (output valid, func, vec_x, vec_y, vec_z, input ready);
  modport sink (input valid, func, vec_x, vec_y, vec_z, output ready);
endinterface

interface pei_out_if;
  import pei_pkg::*;
  logic valid;
  logic ready;
  q16_t pos_x;
  q16_t pos_y;
  q16_t pos_z;
  q16_t vel_x;
  q16_t vel_y;
  q16_t vel_z;
  logic saturated;

  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, saturated,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, saturated,
                output ready);
endinterface

`default_nettype wire

>>> design/pei_lane.sv
`default_nettype none

module pei_lane (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  pei_pkg::lane_cmd_t cmd_i,
  input  pei_pkg::q16_t      vec_i,
  input  pei_pkg::q16_t      accel_i,
  input  wire  [30:0]        time_step_i,
  input  wire  [30:0]        inv_mass_i,
  input  wire  [30:0]        hdt2_i,
  input  wire  [16:0]        drag_i,
  output pei_pkg::q16_t      pos_o,
  output pei_pkg::q16_t      vel_o,
  output logic               sat_o
);
  import pei_pkg::*;

  q16_t p_q, p_d;
  q16_t v_q, v_d;
  q16_t f_q, f_d;
  q16_t acc_q, acc_d;
  q16_t vt_q, vt_d;
  logic sat_q, sat_d;
  logic signed [63:0] prod_q, prod_d;
  q16_t mul_a;
  logic [30:0] mul_b;
  logic signed [31:0] mul_b_s;
  q16_res_t post;
  q16_res_t r_add;

  // operand select for the product issued in this step
  always_comb begin
    mul_a = f_q;
    mul_b = inv_mass_i;
    unique case (cmd_i.step)
      STEP_ISSUE: begin
        mul_a = f_q;
        mul_b = inv_mass_i;
      end
      STEP_ACC: begin
        mul_a = v_q;
        mul_b = time_step_i;
      end
      STEP_POS1: begin
        mul_a = acc_q;
        mul_b = time_step_i;
      end
      STEP_VEL1: begin
        mul_a = accel_i;
        mul_b = hdt2_i;
      end
      STEP_POS2: begin
        mul_a = vt_q;
        mul_b = {14'd0, drag_i};
      end
      default: begin
        mul_a = f_q;
        mul_b = inv_mass_i;
      end
    endcase
  end

  assign mul_b_s = $signed({1'b0, mul_b});
  assign prod_d  = mul_a * mul_b_s;
  assign post    = mul_post(prod_q);

  always_comb begin
    p_d   = p_q;
    v_d   = v_q;
    f_d   = f_q;
    acc_d = acc_q;
    vt_d  = vt_q;
    sat_d = sat_q;
    r_add = '0;
    if (cmd_i.start) begin
      unique case (cmd_i.func)
        FUNC_FORCE: begin
          r_add = sat_add(f_q, vec_i);
          f_d   = r_add.val;
          sat_d = r_add.sat;
        end
        FUNC_STEP: begin
          sat_d = 1'b0;
        end
        FUNC_LOADP: begin
          p_d   = vec_i;
          sat_d = 1'b0;
        end
        FUNC_LOADV: begin
          v_d   = vec_i;
          sat_d = 1'b0;
        end
        default: begin
          sat_d = 1'b0;
        end
      endcase
    end else if (cmd_i.run) begin
      unique case (cmd_i.step)
        STEP_ACC: begin
          r_add = sat_add(accel_i, post.val);
          acc_d = r_add.val;
          sat_d = sat_q | post.sat | r_add.sat;
        end
        STEP_POS1, STEP_POS2: begin
          r_add = sat_add(p_q, post.val);
          p_d   = r_add.val;
          sat_d = sat_q | post.sat | r_add.sat;
        end
        STEP_VEL1: begin
          r_add = sat_add(v_q, post.val);
          vt_d  = r_add.val;
          sat_d = sat_q | post.sat | r_add.sat;
        end
        STEP_VEL2: begin
          v_d   = post.val;
          f_d   = '0;
          sat_d = sat_q | post.sat;
        end
        default: begin
          sat_d = sat_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q   <= '0;
      v_q   <= '0;
      f_q   <= '0;
      sat_q <= 1'b0;
    end else begin
      p_q   <= p_d;
      v_q   <= v_d;
      f_q   <= f_d;
      sat_q <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    vt_q  <= vt_d;
    if (cmd_i.run) begin
      prod_q <= prod_d;
    end
  end

  assign pos_o = p_q;
  assign vel_o = v_q;
  assign sat_o = sat_q;

endmodule

`default_nettype wire

>>> design/pei_ctrl.sv
`default_nettype none

module pei_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  input  wire  [1:0]         in_func_i,
  input  wire  [30:0]        time_step_i,
  input  wire                slot_free_i,
  output logic               in_ready_o,
  output pei_pkg::lane_cmd_t cmd_o,
  output logic [30:0]        hdt2_o,
  output logic               sat_o,
  output logic               load_o
);
  import pei_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [2:0]  step_q, step_d;
  logic        sat_q, sat_d;
  logic [61:0] dtsq_q;
  logic [30:0] hdt2_q;
  logic [62:0] dtsq_rnd;
  logic [45:0] hdt2_full;
  logic        hdt2_ovf;
  logic        start;
  logic        run;

  assign in_ready_o = (state_q == ST_IDLE);
  assign start      = in_valid_i && in_ready_o;
  assign run        = (state_q == ST_RUN);
  assign load_o     = (state_q == ST_DONE) && slot_free_i;

  // half dt squared, rounded at 17 bits
  assign dtsq_rnd  = {1'b0, dtsq_q} + 63'd65536;
  assign hdt2_full = dtsq_rnd[62:17];
  assign hdt2_ovf  = |hdt2_full[45:31];

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_func_i == FUNC_STEP) begin
            state_d = ST_RUN;
            step_d  = STEP_ISSUE;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_RUN: begin
        if (step_q == STEP_LAST) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      ST_DONE: begin
        if (slot_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    sat_d = sat_q;
    if (start) begin
      sat_d = 1'b0;
    end else if (run && (step_q == STEP_ACC) && hdt2_ovf) begin
      sat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_ISSUE;
      sat_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      sat_q   <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (run && (step_q == STEP_ISSUE)) begin
      dtsq_q <= time_step_i * time_step_i;
    end
    if (run && (step_q == STEP_ACC)) begin
      hdt2_q <= hdt2_ovf ? 31'h7FFF_FFFF : hdt2_full[30:0];
    end
  end

  assign cmd_o.start = start;
  assign cmd_o.func  = in_func_i;
  assign cmd_o.run   = run;
  assign cmd_o.step  = step_q;
  assign hdt2_o      = hdt2_q;
  assign sat_o       = sat_q;

endmodule

`default_nettype wire

>>> design/pei_merge.sv
`default_nettype none

module pei_merge (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            load_i,
  input  pei_pkg::vec3_t pos_i,
  input  pei_pkg::vec3_t vel_i,
  input  wire  [2:0]     lane_sat_i,
  input  wire            ctrl_sat_i,
  output logic           slot_free_o,
  pei_out_if.source      out_o
);
  import pei_pkg::*;

  logic  valid_q;
  vec3_t pos_q;
  vec3_t vel_q;
  logic  sat_q;

  assign slot_free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pos_q <= pos_i;
      vel_q <= vel_i;
      sat_q <= (|lane_sat_i) | ctrl_sat_i;
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.pos_x     = pos_q[0];
  assign out_o.pos_y     = pos_q[1];
  assign out_o.pos_z     = pos_q[2];
  assign out_o.vel_x     = vel_q[0];
  assign out_o.vel_y     = vel_q[1];
  assign out_o.vel_z     = vel_q[2];
  assign out_o.saturated = sat_q;

endmodule

`default_nettype wire

>>> design/particle_euler_integrator_core.sv
// Single particle integrator in signed Q16.16 with three axis lanes side by side. Each word
// on the input channel adds a force, loads position, loads velocity or runs one damped
// Euler step; every word gives one result word with position, velocity and a saturation
// flag. With the sink ready, an add force or load word goes from acceptance straight to
// loading the result register; an integrate word first runs its steps on the single
// multiplier in each lane, which issues the five products of a step one per cycle (the
// shared dt squared product runs beside the first), then applies the last product, loads
// the result register and returns to idle for the next acceptance. A sink that holds off
// adds its stall cycles once the result register is full.
// The input is ready only between items, while the result register lets one finished
// word wait for the sink. Registers sit on the APB port at byte addresses 4*i.
`default_nettype none
`include "assert_macros.svh"

module particle_euler_integrator_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  pei_in_if.sink      in_i,
  pei_out_if.source   out_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pei_pkg::*;

  localparam logic [2:0] REG_TIME_STEP = 3'd0;
  localparam logic [2:0] REG_INV_MASS  = 3'd1;
  localparam logic [2:0] REG_ACCEL_X   = 3'd2;
  localparam logic [2:0] REG_ACCEL_Y   = 3'd3;
  localparam logic [2:0] REG_ACCEL_Z   = 3'd4;
  localparam logic [2:0] REG_DRAG      = 3'd5;

  logic [30:0] time_step_q;
  logic [30:0] inv_mass_q;
  vec3_t       accel_q;
  logic [16:0] drag_q;
  logic [2:0]  reg_idx;
  logic        reg_wr;

  lane_cmd_t   cmd;
  logic [30:0] hdt2;
  logic        ctrl_sat;
  logic        load;
  logic        slot_free;
  vec3_t       vec;
  vec3_t       pos;
  vec3_t       vel;
  logic [2:0]  lane_sat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= 31'd1092;
      inv_mass_q  <= 31'd65536;
      accel_q     <= '0;
      drag_q      <= 17'd65536;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_TIME_STEP: time_step_q <= pwdata[30:0];
        REG_INV_MASS:  inv_mass_q  <= pwdata[30:0];
        REG_ACCEL_X:   accel_q[0]  <= pwdata;
        REG_ACCEL_Y:   accel_q[1]  <= pwdata;
        REG_ACCEL_Z:   accel_q[2]  <= pwdata;
        REG_DRAG:      drag_q      <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TIME_STEP: prdata = {1'b0, time_step_q};
      REG_INV_MASS:  prdata = {1'b0, inv_mass_q};
      REG_ACCEL_X:   prdata = accel_q[0];
      REG_ACCEL_Y:   prdata = accel_q[1];
      REG_ACCEL_Z:   prdata = accel_q[2];
      REG_DRAG:      prdata = {15'd0, drag_q};
      default:       prdata = '0;
    endcase
  end

  pei_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_func_i   (in_i.func),
    .time_step_i (time_step_q),
    .slot_free_i (slot_free),
    .in_ready_o  (in_i.ready),
    .cmd_o       (cmd),
    .hdt2_o      (hdt2),
    .sat_o       (ctrl_sat),
    .load_o      (load)
  );

  assign vec[0] = in_i.vec_x;
  assign vec[1] = in_i.vec_y;
  assign vec[2] = in_i.vec_z;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    pei_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .vec_i       (vec[g]),
      .accel_i     (accel_q[g]),
      .time_step_i (time_step_q),
      .inv_mass_i  (inv_mass_q),
      .hdt2_i      (hdt2),
      .drag_i      (drag_q),
      .pos_o       (pos[g]),
      .vel_o       (vel[g]),
      .sat_o       (lane_sat[g])
    );
  end

  pei_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .pos_i       (pos),
    .vel_i       (vel),
    .lane_sat_i  (lane_sat),
    .ctrl_sat_i  (ctrl_sat),
    .slot_free_o (slot_free),
    .out_o       (out_o)
  );

  `PEI_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_i.valid && in_i.ready |=> !in_i.ready, "input taken while previous word still in work")
  `PEI_ASSERT(a_load_shows_result, clk_i, rst_ni, load |=> out_o.valid, "result load did not raise output valid")
  `PEI_ASSERT_NEVER(a_no_start_in_run, clk_i, rst_ni, cmd.run && cmd.start, "lane start during integrate sequence")

endmodule

`default_nettype wire
